// ===== src/upd_pkg.sv =====
`default_nettype none

package upd_pkg;

    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned GROUP_MAX   = 3;

    localparam logic [7:0] PCT_CHAR = 8'h25;

    typedef struct packed {
        logic [GROUP_MAX-1:0][7:0] data;
        logic [1:0]                cnt;
        logic                      last;
    } group_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    function automatic logic is_hex(input logic [7:0] c);
        return ((c >= 8'h30) && (c <= 8'h39)) ||
               ((c >= 8'h61) && (c <= 8'h66)) ||
               ((c >= 8'h41) && (c <= 8'h46));
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [7:0] v;
        v = 8'h00;
        if ((c >= 8'h30) && (c <= 8'h39))
        begin
            v = c - 8'h30;
        end
        else if ((c >= 8'h61) && (c <= 8'h66))
        begin
            v = c - 8'h57;
        end
        else if ((c >= 8'h41) && (c <= 8'h46))
        begin
            v = c - 8'h37;
        end
        return v[3:0];
    endfunction

endpackage

`default_nettype wire

// ===== src/upd_front.sv =====
`default_nettype none

module upd_front (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic [7:0]            in_byte,
    input  wire logic                  in_last,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire upd_pkg::queue_status_t q_status,
    output logic                       push,
    output upd_pkg::group_t            grp
);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_PCT,
        PH_DIGIT
    } phase_t;

    phase_t     phase_reg;
    phase_t     phase_next;
    logic [7:0] held_reg;
    logic [7:0] held_next;
    logic [1:0] n;
    logic       do_fresh;
    logic       hex;
    logic       accept;

    assign in_stall = q_status.full;
    assign accept   = in_valid && !q_status.full;
    assign hex      = upd_pkg::is_hex(in_byte);

    always_comb
    begin
        grp        = '0;
        n          = 2'd0;
        phase_next = phase_reg;
        held_next  = held_reg;
        do_fresh   = 1'b0;

        unique case (phase_reg)
            PH_PCT:
            begin
                if (hex)
                begin
                    held_next  = in_byte;
                    phase_next = PH_DIGIT;
                end
                else
                begin
                    grp.data[n] = upd_pkg::PCT_CHAR;
                    n           = n + 2'd1;
                    do_fresh    = 1'b1;
                end
            end
            PH_DIGIT:
            begin
                if (hex)
                begin
                    grp.data[n] = {upd_pkg::hex_val(held_reg), upd_pkg::hex_val(in_byte)};
                    n           = n + 2'd1;
                    phase_next  = PH_IDLE;
                end
                else
                begin
                    grp.data[n] = upd_pkg::PCT_CHAR;
                    n           = n + 2'd1;
                    grp.data[n] = held_reg;
                    n           = n + 2'd1;
                    do_fresh    = 1'b1;
                end
            end
            default:
            begin
                do_fresh = 1'b1;
            end
        endcase

        if (do_fresh)
        begin
            if (in_byte == upd_pkg::PCT_CHAR)
            begin
                phase_next = PH_PCT;
            end
            else
            begin
                grp.data[n] = in_byte;
                n           = n + 2'd1;
                phase_next  = PH_IDLE;
            end
        end

        if (in_last)
        begin
            unique case (phase_next)
                PH_PCT:
                begin
                    grp.data[n] = upd_pkg::PCT_CHAR;
                    n           = n + 2'd1;
                end
                PH_DIGIT:
                begin
                    grp.data[n] = upd_pkg::PCT_CHAR;
                    n           = n + 2'd1;
                    grp.data[n] = held_next;
                    n           = n + 2'd1;
                end
                default:
                begin
                end
            endcase
            phase_next = PH_IDLE;
            grp.last   = 1'b1;
        end

        grp.cnt = n;
    end

    assign push = accept && (n != 2'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            held_reg  <= 8'h00;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            held_reg  <= held_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/upd_queue.sv =====
`default_nettype none

module upd_queue #(
    parameter int unsigned DEPTH = upd_pkg::QUEUE_DEPTH
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire upd_pkg::group_t   wr_grp,
    input  wire logic              pop,
    output upd_pkg::group_t        rd_grp,
    output upd_pkg::queue_status_t status
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    upd_pkg::group_t mem [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_next;

    assign status.full  = (count_reg == CNT_W'(DEPTH));
    assign status.empty = (count_reg == '0);
    assign rd_grp       = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= wr_grp;
        end
    end

endmodule

`default_nettype wire

// ===== src/upd_back.sv =====
`default_nettype none

module upd_back (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire upd_pkg::group_t       head,
    input  wire upd_pkg::queue_status_t q_status,
    output logic                       pop,
    output logic [7:0]                 out_byte,
    output logic                       out_last,
    output logic                       out_valid,
    input  wire logic                  out_stall
);

    logic       out_valid_reg;
    logic [7:0] out_byte_reg;
    logic       out_last_reg;
    logic [1:0] idx_reg;
    logic [1:0] idx_next;
    logic [1:0] last_idx;
    logic       load;
    logic       take;
    logic       at_end;

    assign last_idx = head.cnt - 2'd1;
    assign at_end   = (idx_reg == last_idx);
    assign load     = !out_valid_reg || !out_stall;
    assign take     = load && !q_status.empty;
    assign pop      = take && at_end;

    always_comb
    begin
        idx_next = idx_reg;
        if (pop)
        begin
            idx_next = 2'd0;
        end
        else if (take)
        begin
            idx_next = idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            idx_reg       <= 2'd0;
        end
        else
        begin
            if (load)
            begin
                out_valid_reg <= !q_status.empty;
            end
            idx_reg <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            out_byte_reg <= head.data[idx_reg];
            out_last_reg <= head.last && at_end;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign out_last  = out_last_reg;

endmodule

`default_nettype wire

// ===== src/url_percent_decoder_core.sv =====
// With the queue empty, the first decoded beat of an accepted input beat is written into
// the group queue and then into the output register, from which it is presented.
// Throughput: one input beat per cycle while each yields at most one decoded beat and
// out_stall is low; a beat yielding n decoded beats holds the single output register
// for each in turn; the group queue (QUEUE_DEPTH entries) absorbs this until it fills.
// Reset: rst_n is asynchronous and active low; it clears the escape phase, the queue
// and the output valid flag, and nothing is held afterwards.
`default_nettype none

module url_percent_decoder_core #(
    parameter int unsigned QUEUE_DEPTH = upd_pkg::QUEUE_DEPTH
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic [7:0] in_byte,
    input  wire logic       in_last,
    input  wire logic       in_valid,
    output logic            in_stall,
    output logic [7:0]      out_byte,
    output logic            out_last,
    output logic            out_valid,
    input  wire logic       out_stall
);

    upd_pkg::group_t        wr_grp;
    upd_pkg::group_t        rd_grp;
    upd_pkg::queue_status_t q_status;
    logic                   push;
    logic                   pop;

    upd_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_byte  (in_byte),
        .in_last  (in_last),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .q_status (q_status),
        .push     (push),
        .grp      (wr_grp)
    );

    upd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .wr_grp (wr_grp),
        .pop    (pop),
        .rd_grp (rd_grp),
        .status (q_status)
    );

    upd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (rd_grp),
        .q_status  (q_status),
        .pop       (pop),
        .out_byte  (out_byte),
        .out_last  (out_last),
        .out_valid (out_valid),
        .out_stall (out_stall)
    );

endmodule

`default_nettype wire

// ===== src/upd_checker.sv =====
`default_nettype none

module upd_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_valid,
    input wire logic       in_stall,
    input wire logic [7:0] out_byte,
    input wire logic       out_last,
    input wire logic       out_valid,
    input wire logic       out_stall
);

    // A stalled output beat keeps its payload.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(out_last))
        else $error("stalled output beat changed");

    // A fresh output beat after an idle output follows an earlier accepted input beat.
    a_rise_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && !in_stall, 2))
        else $error("output beat appeared without a matching input beat");

    // The queue cannot be full while the output register is empty.
    a_no_stall_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("input stalled while output idle");

endmodule

bind url_percent_decoder_core upd_checker u_upd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_byte  (out_byte),
    .out_last  (out_last),
    .out_valid (out_valid),
    .out_stall (out_stall)
);

`default_nettype wire
